### sv/calendar_clock_with_weekday_unit_defines.svh
// Assertion macros shared by the calendar clock RTL.
`ifndef CALENDAR_CLOCK_WITH_WEEKDAY_UNIT_DEFINES_SVH
`define CALENDAR_CLOCK_WITH_WEEKDAY_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// Checks a property on every rising clock edge outside of reset.
`define CCW_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("calendar clock assertion failed");
// Checks that an expression is never true outside of reset.
`define CCW_ASSERT_NEVER(label, expr) \
  `CCW_ASSERT(label, !(expr))
`else
`define CCW_ASSERT(label, prop)
`define CCW_ASSERT_NEVER(label, expr)
`endif

`endif

### sv/ccw_pkg.sv
// Types, constants and helper functions of the calendar clock unit.
package ccw_pkg;

  typedef enum logic {
    ACT_TICK = 1'b0,
    ACT_LOAD = 1'b1
  } action_e;

  typedef struct packed {
    action_e     action;
    logic [5:0]  load_sec;
    logic [5:0]  load_min;
    logic [4:0]  load_hour;
    logic [4:0]  load_day;
    logic [3:0]  load_month;
    logic [13:0] load_year;
  } ccw_in_t;

  typedef struct packed {
    logic [5:0]  seconds;
    logic [5:0]  minutes;
    logic [4:0]  hours;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [13:0] year;
    logic [2:0]  weekday;
  } ccw_out_t;

  typedef struct packed {
    logic [5:0]  seconds;
    logic [5:0]  minutes;
    logic [4:0]  hours;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [13:0] year;
  } ccw_date_t;

  localparam logic [5:0]  SEC_LAST   = 6'd59;
  localparam logic [5:0]  MIN_LAST   = 6'd59;
  localparam logic [4:0]  HOUR_LAST  = 5'd23;
  localparam logic [3:0]  MONTH_LAST = 4'd12;
  localparam logic [13:0] YEAR_LAST  = 14'd9999;
  localparam logic [3:0]  MONTH_FEB  = 4'd2;
  localparam logic [4:0]  FEB_LEAP_LEN = 5'd29;

  // Reset date is 2023-05-31 23:59:00.
  localparam ccw_date_t RESET_DATE = '{
    seconds: 6'd0,
    minutes: 6'd59,
    hours:   5'd23,
    day:     5'd31,
    month:   4'd5,
    year:    14'd2023
  };

  localparam logic [14:0] YEAR_BIAS  = 15'd400;
  localparam logic [14:0] DIV25_MUL  = 15'd20972;

  // Nominal month length; months outside 1..12 count 31 days.
  function automatic logic [4:0] month_len(input logic [3:0] m);
    logic [4:0] len;
    unique case (m)
      4'd2:                      len = 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

  // Month term of the weekday formula: floor(3 * (m + 1) / 5).
  function automatic logic [3:0] month_term(input logic [3:0] m);
    logic [3:0] t;
    unique case (m)
      4'd0:              t = 4'd0;
      4'd1, 4'd2:        t = 4'd1;
      4'd3:              t = 4'd2;
      4'd4, 4'd5:        t = 4'd3;
      4'd6, 4'd7:        t = 4'd4;
      4'd8:              t = 4'd5;
      4'd9, 4'd10:       t = 4'd6;
      4'd11, 4'd12:      t = 4'd7;
      4'd13:             t = 4'd8;
      default:           t = 4'd9;
    endcase
    return t;
  endfunction

  // Quotient by 25 through a reciprocal multiply; exact for every 14-bit input.
  function automatic logic [9:0] div25(input logic [13:0] x);
    logic [28:0] prod;
    prod = 29'(x) * 29'(DIV25_MUL);
    return prod[28:19];
  endfunction

endpackage

### sv/calendar_clock_with_weekday_unit.sv
// Calendar clock with day of week: one tick or load per transaction, one result each.
//
// Each accepted transaction is either a one-second tick or a load of a full date and
// time, and yields one result with the date, time and weekday (0 is Sunday) after it.
// The unit takes one transaction per clock cycle while its input is not stalled. The date
// counters are updated in the accepting cycle, so ticks and loads may follow each other in
// consecutive cycles; a result passes from the date register through two further register
// stages that compute the weekday (a reciprocal multiply for the century term, then the
// sum and its reduction modulo seven). The stages advance whenever the stage after them is
// empty or moves, so the input is stalled only while all three stages hold results and the
// output is stalled.
module calendar_clock_with_weekday_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  ccw_pkg::ccw_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output ccw_pkg::ccw_out_t out_data_o
);

  `include "calendar_clock_with_weekday_unit_defines.svh"

  logic accept;
  logic en2, en3;
  logic v1_q, v2_q, v3_q;
  logic is_load, sec_below;
  logic [5:0] sec_inc;

  ccw_pkg::ccw_date_t date_q, date_d;

  // Leap year and month length of the current date.
  logic [9:0]  y_q25;
  logic [13:0] y_rem25;
  logic        y_div4, y_div16, y_div25, y_leap;
  logic [4:0]  dim;

  // Weekday stage one.
  logic [14:0] yy;
  logic [3:0]  mm;
  logic [14:0] pre_d;
  logic [7:0]  q100_d;
  ccw_pkg::ccw_date_t date2_q;
  logic [14:0] pre_q;
  logic [7:0]  q100_q;

  // Weekday stage two.
  logic [14:0] wd_sum;
  logic [5:0]  fold1;
  logic [3:0]  fold2;
  logic [2:0]  wd;
  ccw_pkg::ccw_out_t out_q;

  assign en3        = !v3_q || !out_stall_i;
  assign en2        = !v2_q || en3;
  assign in_stall_o = v1_q && !en2;
  assign accept     = in_valid_i && !in_stall_o;

  assign is_load   = (in_data_i.action == ccw_pkg::ACT_LOAD);
  assign sec_below = (date_q.seconds < ccw_pkg::SEC_LAST);
  assign sec_inc   = date_q.seconds + 6'd1;

  assign y_q25   = ccw_pkg::div25(date_q.year);
  assign y_rem25 = date_q.year - 14'({y_q25, 4'b0000} + {1'b0, y_q25, 3'b000} + 14'(y_q25));
  assign y_div25 = (y_rem25 == 14'd0);
  assign y_div4  = (date_q.year[1:0] == 2'b00);
  assign y_div16 = (date_q.year[3:0] == 4'b0000);
  // Divisible by 400 is divisible by 16 and 25; divisible by 100 is by 4 and 25.
  assign y_leap  = (y_div16 && y_div25) || (y_div4 && !y_div25);
  assign dim     = (date_q.month == ccw_pkg::MONTH_FEB && y_leap) ? ccw_pkg::FEB_LEAP_LEN
                 : ccw_pkg::month_len(date_q.month);

  always_comb begin
    date_d = date_q;
    if (is_load) begin
      date_d.seconds = in_data_i.load_sec;
      date_d.minutes = in_data_i.load_min;
      date_d.hours   = in_data_i.load_hour;
      date_d.day     = in_data_i.load_day;
      date_d.month   = in_data_i.load_month;
      date_d.year    = in_data_i.load_year;
    end else if (sec_below) begin
      date_d.seconds = sec_inc;
    end else begin
      date_d.seconds = 6'd0;
      if (date_q.minutes < ccw_pkg::MIN_LAST) begin
        date_d.minutes = date_q.minutes + 6'd1;
      end else begin
        date_d.minutes = 6'd0;
        if (date_q.hours < ccw_pkg::HOUR_LAST) begin
          date_d.hours = date_q.hours + 5'd1;
        end else begin
          date_d.hours = 5'd0;
          if (date_q.day >= dim) begin
            date_d.day = 5'd1;
            if (date_q.month >= ccw_pkg::MONTH_LAST) begin
              date_d.month = 4'd1;
              date_d.year  = (date_q.year >= ccw_pkg::YEAR_LAST) ? 14'd1
                                                                 : date_q.year + 14'd1;
            end else begin
              date_d.month = date_q.month + 4'd1;
            end
          end else begin
            date_d.day = date_q.day + 5'd1;
          end
        end
      end
    end
  end

  // January, February and month zero count as months 13, 14 and 12 of the prior year.
  always_comb begin
    yy = 15'(date_q.year) + ccw_pkg::YEAR_BIAS;
    mm = date_q.month;
    if (date_q.month <= ccw_pkg::MONTH_FEB) begin
      mm = date_q.month + 4'd12;
      yy = yy - 15'd1;
    end
  end

  assign pre_d  = 15'(date_q.day) + 15'({mm, 1'b0}) + 15'(ccw_pkg::month_term(mm)) + 15'd1
                + yy + 15'(yy[14:2]);
  // floor(yy / 100) is floor(floor(yy / 4) / 25).
  assign q100_d = 8'(ccw_pkg::div25(14'(yy[14:2])));

  assign wd_sum = pre_q - 15'(q100_q) + 15'(q100_q[7:2]);
  // Octal digits fold modulo seven since eight leaves one.
  assign fold1  = 6'(wd_sum[2:0]) + 6'(wd_sum[5:3]) + 6'(wd_sum[8:6])
                + 6'(wd_sum[11:9]) + 6'(wd_sum[14:12]);
  assign fold2  = 4'(fold1[5:3]) + 4'(fold1[2:0]);
  assign wd     = (fold2 >= 4'd7) ? 3'(fold2 - 4'd7) : fold2[2:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      date_q <= ccw_pkg::RESET_DATE;
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      v3_q   <= 1'b0;
    end else begin
      if (accept) begin
        date_q <= date_d;
      end
      if (accept) begin
        v1_q <= 1'b1;
      end else if (en2) begin
        v1_q <= 1'b0;
      end
      if (en2) begin
        v2_q <= v1_q;
      end
      if (en3) begin
        v3_q <= v2_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2) begin
      date2_q <= date_q;
      pre_q   <= pre_d;
      q100_q  <= q100_d;
    end
    if (en3) begin
      out_q.seconds <= date2_q.seconds;
      out_q.minutes <= date2_q.minutes;
      out_q.hours   <= date2_q.hours;
      out_q.day     <= date2_q.day;
      out_q.month   <= date2_q.month;
      out_q.year    <= date2_q.year;
      out_q.weekday <= wd;
    end
  end

  assign out_valid_o = v3_q;
  assign out_data_o  = out_q;

  `CCW_ASSERT(a_tick_counts_sec, accept && !is_load && sec_below |=> date_q.seconds == $past(sec_inc))
  `CCW_ASSERT(a_load_takes_year, accept && is_load |=> date_q.year == $past(in_data_i.load_year))
  `CCW_ASSERT(a_result_from_stage, $rose(out_valid_o) |-> $past(v2_q))
  `CCW_ASSERT_NEVER(a_weekday_range, out_valid_o && out_data_o.weekday == 3'd7)

endmodule
